/* design/smop_pkg.sv */
package smop_pkg;

    localparam logic [1:0] MODE_GL   = 2'd0;
    localparam logic [1:0] MODE_EA   = 2'd1;
    localparam logic [1:0] MODE_GRAD = 2'd2;

    localparam logic [1:0] CFG_MODE  = 2'd0;
    localparam logic [1:0] CFG_XFORM = 2'd1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SING    = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    localparam logic [3:0] CNT_NONE = 4'd0;
    localparam logic [3:0] CNT_SYM  = 4'd6;
    localparam logic [3:0] CNT_GRAD = 4'd9;

    localparam int K_SHIFT = 30;
    localparam logic signed [31:0] K_SQRT2         = 32'sd1518500250;
    localparam logic signed [31:0] K_INV_SQRT3     = 32'sd619925131;
    localparam logic signed [31:0] K_INV_SQRT2     = 32'sd759250125;
    localparam logic signed [31:0] K_INV_SQRT6     = 32'sd438353264;
    localparam logic signed [31:0] K_TWO_INV_SQRT6 = 32'sd876706528;
    localparam logic signed [63:0] K_HALF          = 64'sd1 <<< (K_SHIFT - 1);

    // symmetric entry order: 11, 22, 33, 23, 13, 12
    localparam int MI [6] = '{0, 1, 2, 1, 0, 0};
    localparam int MJ [6] = '{0, 1, 2, 2, 2, 1};

    typedef struct packed {
        logic ea;
        logic grad;
        logic xf;
        logic clip;
        logic sing;
    } t_ctl;

    function automatic int sym_idx(input int r, input int c);
        return (r == c) ? r : 6 - r - c;
    endfunction

    function automatic int inc3(input int x);
        return (x == 2) ? 0 : x + 1;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) begin
            return 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return v[31:0];
    endfunction

    function automatic logic clip32(input logic signed [63:0] v);
        return (v > 64'sd2147483647) || (v < -64'sd2147483648);
    endfunction

endpackage

/* design/strain_metric_order_parameters.sv */
// channel  | handshake                       | payload
// in       | i_in_valid / o_in_ready         | i_f_r1c1 .. i_f_r3c3
// out      | o_out_valid / i_out_ready       | o_value_0 .. o_value_8, o_value_count, o_status
// cfg      | i_cfg_valid / o_cfg_ready       | i_cfg_index, i_cfg_data
//
// one item per cycle unless the output stalls; the pipeline is the 34 restoring divider stages
// of the inverse plus stages of products, sums and rounding
// synchronous active-low reset empties the pipeline and restores the registers
// the whole pipeline holds while the output register is full and not taken
module strain_metric_order_parameters #(
    parameter int FRAC_BITS = 28
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic signed [31:0] i_f_r1c1,
    input  logic signed [31:0] i_f_r1c2,
    input  logic signed [31:0] i_f_r1c3,
    input  logic signed [31:0] i_f_r2c1,
    input  logic signed [31:0] i_f_r2c2,
    input  logic signed [31:0] i_f_r2c3,
    input  logic signed [31:0] i_f_r3c1,
    input  logic signed [31:0] i_f_r3c2,
    input  logic signed [31:0] i_f_r3c3,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_value_0,
    output logic signed [31:0] o_value_1,
    output logic signed [31:0] o_value_2,
    output logic signed [31:0] o_value_3,
    output logic signed [31:0] o_value_4,
    output logic signed [31:0] o_value_5,
    output logic signed [31:0] o_value_6,
    output logic signed [31:0] o_value_7,
    output logic signed [31:0] o_value_8,
    output logic [3:0]         o_value_count,
    output logic [1:0]         o_status,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [1:0]         i_cfg_data
);
    import smop_pkg::*;

    localparam int RPW = 65 - FRAC_BITS;
    localparam int SW  = RPW + 2;
    localparam int QB  = 34;
    localparam int EW  = (SW > QB + 2) ? SW : QB + 2;
    localparam int CW  = SW + QB + 1;
    localparam logic signed [63:0] ONE  = 64'sd1 <<< FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [EW-1:0] E_BIG = EW'(64'sd1 <<< (EW - 2));

    function automatic logic signed [RPW-1:0] mulq(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = a * b;
        p = p + HALF;
        return RPW'(p >>> FRAC_BITS);
    endfunction

    logic [1:0] r_mode;
    logic       r_xform;
    logic       adv;
    logic       r_out_v;
    logic signed [31:0] in_f [9];

    assign adv         = !r_out_v || i_out_ready;
    assign o_in_ready  = adv;
    assign o_cfg_ready = 1'b1;
    assign in_f[0] = i_f_r1c1;
    assign in_f[1] = i_f_r1c2;
    assign in_f[2] = i_f_r1c3;
    assign in_f[3] = i_f_r2c1;
    assign in_f[4] = i_f_r2c2;
    assign in_f[5] = i_f_r2c3;
    assign in_f[6] = i_f_r3c1;
    assign in_f[7] = i_f_r3c2;
    assign in_f[8] = i_f_r3c3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_GL;
            r_xform <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MODE:  r_mode  <= i_cfg_data;
                CFG_XFORM: r_xform <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid bits
    logic r_s1_v, r_s2_v, r_s3_v, r_s4_v, r_s5_v, r_s6_v;
    logic r_dv [QB+1];
    logic r_s8_v, r_s9_v, r_s10_v, r_s11_v;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0; r_s2_v <= 1'b0; r_s3_v <= 1'b0;
            r_s4_v <= 1'b0; r_s5_v <= 1'b0; r_s6_v <= 1'b0;
            for (int k = 0; k <= QB; k++) begin
                r_dv[k] <= 1'b0;
            end
            r_s8_v <= 1'b0; r_s9_v <= 1'b0; r_s10_v <= 1'b0; r_s11_v <= 1'b0;
            r_out_v <= 1'b0;
        end else if (adv) begin
            r_s1_v <= i_in_valid;
            r_s2_v <= r_s1_v;
            r_s3_v <= r_s2_v;
            r_s4_v <= r_s3_v;
            r_s5_v <= r_s4_v;
            r_s6_v <= r_s5_v;
            r_dv[0] <= r_s6_v;
            for (int k = 1; k <= QB; k++) begin
                r_dv[k] <= r_dv[k-1];
            end
            r_s8_v  <= r_dv[QB];
            r_s9_v  <= r_s8_v;
            r_s10_v <= r_s9_v;
            r_s11_v <= r_s10_v;
            r_out_v <= r_s11_v;
        end
    end

    // stage 1: entry products
    t_ctl n_s1_c, r_s1_c;
    logic signed [RPW-1:0] n_s1_p [6][3];
    logic signed [RPW-1:0] r_s1_p [6][3];
    logic signed [31:0]    r_s1_f [9];

    always_comb begin
        logic signed [31:0] a;
        logic signed [31:0] b;
        n_s1_c.ea   = (r_mode == MODE_EA);
        n_s1_c.grad = (r_mode == MODE_GRAD);
        n_s1_c.xf   = r_xform;
        n_s1_c.clip = 1'b0;
        n_s1_c.sing = 1'b0;
        for (int m = 0; m < 6; m++) begin
            for (int k = 0; k < 3; k++) begin
                if (n_s1_c.ea) begin
                    a = in_f[MI[m]*3 + k];
                    b = in_f[MJ[m]*3 + k];
                end else begin
                    a = in_f[k*3 + MI[m]];
                    b = in_f[k*3 + MJ[m]];
                end
                n_s1_p[m][k] = mulq(a, b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1_c <= n_s1_c;
            r_s1_p <= n_s1_p;
            r_s1_f <= in_f;
        end
    end

    // stage 2: sums, green-lagrange entries and saturated b
    t_ctl n_s2_c, r_s2_c;
    logic signed [EW-1:0] n_s2_e [6];
    logic signed [EW-1:0] r_s2_e [6];
    logic signed [31:0]   n_s2_b [6];
    logic signed [31:0]   r_s2_b [6];
    logic signed [31:0]   r_s2_f [9];

    always_comb begin
        logic signed [SW-1:0] s;
        logic signed [63:0]   t;
        n_s2_c = r_s1_c;
        for (int m = 0; m < 6; m++) begin
            s = SW'(r_s1_p[m][0]) + SW'(r_s1_p[m][1]) + SW'(r_s1_p[m][2]);
            t = 64'(s) - ((m < 3) ? ONE : 64'sd0) + 64'sd1;
            n_s2_e[m] = EW'(t >>> 1);
            n_s2_b[m] = sat32(64'(s));
            if (r_s1_c.ea && clip32(64'(s))) begin
                n_s2_c.clip = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s2_c <= n_s2_c;
            r_s2_e <= n_s2_e;
            r_s2_b <= n_s2_b;
            r_s2_f <= r_s1_f;
        end
    end

    // stage 3: adjugate products
    t_ctl r_s3_c;
    logic signed [RPW-1:0] n_s3_pa [6];
    logic signed [RPW-1:0] n_s3_pb [6];
    logic signed [RPW-1:0] r_s3_pa [6];
    logic signed [RPW-1:0] r_s3_pb [6];
    logic signed [EW-1:0]  r_s3_e [6];
    logic signed [31:0]    r_s3_b [6];
    logic signed [31:0]    r_s3_f [9];

    always_comb begin
        int i1, i2, j1, j2;
        for (int m = 0; m < 6; m++) begin
            i1 = inc3(MI[m]);
            i2 = inc3(i1);
            j1 = inc3(MJ[m]);
            j2 = inc3(j1);
            n_s3_pa[m] = mulq(r_s2_b[sym_idx(j1, i1)], r_s2_b[sym_idx(j2, i2)]);
            n_s3_pb[m] = mulq(r_s2_b[sym_idx(j1, i2)], r_s2_b[sym_idx(j2, i1)]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s3_c  <= r_s2_c;
            r_s3_pa <= n_s3_pa;
            r_s3_pb <= n_s3_pb;
            r_s3_e  <= r_s2_e;
            r_s3_b  <= r_s2_b;
            r_s3_f  <= r_s2_f;
        end
    end

    // stage 4: adjugate entries
    t_ctl n_s4_c, r_s4_c;
    logic signed [31:0]   n_s4_adj [6];
    logic signed [31:0]   r_s4_adj [6];
    logic signed [EW-1:0] r_s4_e [6];
    logic signed [31:0]   r_s4_b [6];
    logic signed [31:0]   r_s4_f [9];

    always_comb begin
        logic signed [63:0] d;
        n_s4_c = r_s3_c;
        for (int m = 0; m < 6; m++) begin
            d = 64'(r_s3_pa[m]) - 64'(r_s3_pb[m]);
            n_s4_adj[m] = sat32(d);
            if (r_s3_c.ea && clip32(d)) begin
                n_s4_c.clip = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s4_c   <= n_s4_c;
            r_s4_adj <= n_s4_adj;
            r_s4_e   <= r_s3_e;
            r_s4_b   <= r_s3_b;
            r_s4_f   <= r_s3_f;
        end
    end

    // stage 5: determinant products
    t_ctl r_s5_c;
    logic signed [RPW-1:0] r_s5_dp [3];
    logic signed [31:0]    r_s5_adj [6];
    logic signed [EW-1:0]  r_s5_e [6];
    logic signed [31:0]    r_s5_f [9];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s5_c     <= r_s4_c;
            r_s5_dp[0] <= mulq(r_s4_b[0], r_s4_adj[0]);
            r_s5_dp[1] <= mulq(r_s4_b[5], r_s4_adj[5]);
            r_s5_dp[2] <= mulq(r_s4_b[4], r_s4_adj[4]);
            r_s5_adj   <= r_s4_adj;
            r_s5_e     <= r_s4_e;
            r_s5_f     <= r_s4_f;
        end
    end

    // stage 6: determinant
    t_ctl n_s6_c, r_s6_c;
    logic signed [SW-1:0] n_s6_det, r_s6_det;
    logic signed [31:0]   r_s6_adj [6];
    logic signed [EW-1:0] r_s6_e [6];
    logic signed [31:0]   r_s6_f [9];

    always_comb begin
        n_s6_det = SW'(r_s5_dp[0]) + SW'(r_s5_dp[1]) + SW'(r_s5_dp[2]);
        n_s6_c = r_s5_c;
        n_s6_c.sing = r_s5_c.ea && (n_s6_det == '0);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s6_c   <= n_s6_c;
            r_s6_det <= n_s6_det;
            r_s6_adj <= r_s5_adj;
            r_s6_e   <= r_s5_e;
            r_s6_f   <= r_s5_f;
        end
    end

    // divider: index 0 is the setup stage, then one quotient bit per stage
    t_ctl               r_dc   [QB+1];
    logic signed [31:0] r_df   [QB+1][9];
    logic signed [EW-1:0] r_de [QB+1][6];
    logic [SW-1:0]      r_dd   [QB+1];
    logic [CW-1:0]      r_drem [QB+1][6];
    logic [QB-1:0]      r_dq   [QB+1][6];
    logic               r_dovf [QB+1][6];
    logic               r_dneg [QB+1][6];
    logic [SW-1:0]      n_d0;
    logic [CW-1:0]      n_rem0 [6];
    logic               n_ovf0 [6];
    logic               n_neg0 [6];
    logic [CW-1:0]      n_drem [QB+1][6];
    logic [QB-1:0]      n_dq   [QB+1][6];

    always_comb begin
        logic [31:0] mag;
        n_d0 = r_s6_det[SW-1] ? ($unsigned(~r_s6_det) + SW'(1)) : $unsigned(r_s6_det);
        for (int m = 0; m < 6; m++) begin
            mag = r_s6_adj[m][31] ? ($unsigned(~r_s6_adj[m]) + 32'd1)
                                  : $unsigned(r_s6_adj[m]);
            n_rem0[m] = CW'(mag) << FRAC_BITS;
            n_ovf0[m] = n_rem0[m] >= (CW'(n_d0) << QB);
            n_neg0[m] = r_s6_adj[m][31] ^ r_s6_det[SW-1];
        end
    end

    always_comb begin
        logic [CW-1:0] sh;
        for (int m = 0; m < 6; m++) begin
            n_drem[0][m] = '0;
            n_dq[0][m]   = '0;
        end
        for (int k = 1; k <= QB; k++) begin
            sh = CW'(r_dd[k-1]) << (QB - k);
            for (int m = 0; m < 6; m++) begin
                if (r_drem[k-1][m] >= sh) begin
                    n_drem[k][m] = r_drem[k-1][m] - sh;
                    n_dq[k][m]   = r_dq[k-1][m] | (QB'(1) << (QB - k));
                end else begin
                    n_drem[k][m] = r_drem[k-1][m];
                    n_dq[k][m]   = r_dq[k-1][m];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dc[0] <= r_s6_c;
            r_df[0] <= r_s6_f;
            r_de[0] <= r_s6_e;
            r_dd[0] <= n_d0;
            for (int m = 0; m < 6; m++) begin
                r_drem[0][m] <= n_rem0[m];
                r_dq[0][m]   <= '0;
                r_dovf[0][m] <= n_ovf0[m];
                r_dneg[0][m] <= n_neg0[m];
            end
            for (int k = 1; k <= QB; k++) begin
                r_dc[k] <= r_dc[k-1];
                r_df[k] <= r_df[k-1];
                r_de[k] <= r_de[k-1];
                r_dd[k] <= r_dd[k-1];
                for (int m = 0; m < 6; m++) begin
                    r_drem[k][m] <= n_drem[k][m];
                    r_dq[k][m]   <= n_dq[k][m];
                    r_dovf[k][m] <= r_dovf[k-1][m];
                    r_dneg[k][m] <= r_dneg[k-1][m];
                end
            end
        end
    end

    // stage 8: euler-almansi entries from the inverse, or the green-lagrange entries outside that mode
    t_ctl r_s8_c;
    logic signed [EW-1:0] n_s8_e [6];
    logic signed [EW-1:0] r_s8_e [6];
    logic signed [31:0]   r_s8_f [9];

    always_comb begin
        logic signed [QB:0] q;
        logic signed [QB:0] inv;
        logic signed [63:0] t;
        for (int m = 0; m < 6; m++) begin
            q   = $signed({1'b0, r_dq[QB][m]});
            inv = r_dneg[QB][m] ? -q : q;
            t   = ((m < 3) ? ONE : 64'sd0) - 64'(inv) + 64'sd1;
            if (!r_dc[QB].ea) begin
                n_s8_e[m] = r_de[QB][m];
            end else if (r_dovf[QB][m]) begin
                n_s8_e[m] = r_dneg[QB][m] ? E_BIG : -E_BIG;
            end else begin
                n_s8_e[m] = EW'(t >>> 1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s8_c <= r_dc[QB];
            r_s8_e <= n_s8_e;
            r_s8_f <= r_df[QB];
        end
    end

    // stage 9: saturate, weight shear terms
    t_ctl n_s9_c, r_s9_c;
    logic signed [31:0] n_s9_u [3];
    logic signed [31:0] r_s9_u [3];
    logic signed [63:0] n_s9_p [3];
    logic signed [63:0] r_s9_p [3];
    logic signed [31:0] r_s9_f [9];

    always_comb begin
        logic signed [31:0] se;
        n_s9_c = r_s8_c;
        for (int m = 0; m < 6; m++) begin
            se = sat32(64'(r_s8_e[m]));
            if (clip32(64'(r_s8_e[m]))) begin
                n_s9_c.clip = 1'b1;
            end
            if (m < 3) begin
                n_s9_u[m] = se;
            end else begin
                n_s9_p[m-3] = se * K_SQRT2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s9_c <= n_s9_c;
            r_s9_u <= n_s9_u;
            r_s9_p <= n_s9_p;
            r_s9_f <= r_s8_f;
        end
    end

    // stage 10: round weighted terms
    t_ctl n_s10_c, r_s10_c;
    logic signed [31:0] n_s10_u [6];
    logic signed [31:0] r_s10_u [6];
    logic signed [31:0] r_s10_f [9];

    always_comb begin
        logic signed [63:0] r;
        n_s10_c = r_s9_c;
        for (int m = 0; m < 3; m++) begin
            n_s10_u[m] = r_s9_u[m];
            r = (r_s9_p[m] + K_HALF) >>> K_SHIFT;
            n_s10_u[m+3] = sat32(r);
            if (clip32(r)) begin
                n_s10_c.clip = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s10_c <= n_s10_c;
            r_s10_u <= n_s10_u;
            r_s10_f <= r_s9_f;
        end
    end

    // stage 11: transform products
    t_ctl r_s11_c;
    logic signed [63:0] n_s11_t [6];
    logic signed [63:0] r_s11_t [6];
    logic signed [31:0] r_s11_u [6];
    logic signed [31:0] r_s11_f [9];

    always_comb begin
        logic signed [33:0] s;
        s = 34'(r_s10_u[0]) + 34'(r_s10_u[1]) + 34'(r_s10_u[2]);
        n_s11_t[0] = K_INV_SQRT3 * s;
        n_s11_t[1] = K_INV_SQRT2 * r_s10_u[0];
        n_s11_t[2] = K_INV_SQRT2 * r_s10_u[1];
        n_s11_t[3] = K_TWO_INV_SQRT6 * r_s10_u[2];
        n_s11_t[4] = K_INV_SQRT6 * r_s10_u[0];
        n_s11_t[5] = K_INV_SQRT6 * r_s10_u[1];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s11_c <= r_s10_c;
            r_s11_t <= n_s11_t;
            r_s11_u <= r_s10_u;
            r_s11_f <= r_s10_f;
        end
    end

    // output register
    logic signed [31:0] n_out_val [9];
    logic signed [31:0] r_out_val [9];
    logic [3:0] n_out_cnt, r_out_cnt;
    logic [1:0] n_out_st, r_out_st;

    always_comb begin
        logic signed [63:0] x [3];
        logic clip;
        x[0] = (r_s11_t[0] + K_HALF) >>> K_SHIFT;
        x[1] = (r_s11_t[1] - r_s11_t[2] + K_HALF) >>> K_SHIFT;
        x[2] = (r_s11_t[3] - r_s11_t[4] - r_s11_t[5] + K_HALF) >>> K_SHIFT;
        clip = r_s11_c.clip || (r_s11_c.xf && (clip32(x[0]) || clip32(x[1]) || clip32(x[2])));
        for (int i = 0; i < 9; i++) begin
            n_out_val[i] = '0;
        end
        if (r_s11_c.grad) begin
            if (r_s11_c.xf) begin
                n_out_cnt = CNT_NONE;
                n_out_st  = ST_REFUSED;
            end else begin
                n_out_cnt = CNT_GRAD;
                n_out_st  = ST_OK;
                n_out_val = r_s11_f;
            end
        end else if (r_s11_c.sing) begin
            n_out_cnt = CNT_NONE;
            n_out_st  = ST_SING;
        end else begin
            n_out_cnt = CNT_SYM;
            n_out_st  = clip ? ST_SAT : ST_OK;
            if (r_s11_c.xf) begin
                n_out_val[0] = sat32(x[0]);
                n_out_val[1] = sat32(x[1]);
                n_out_val[2] = sat32(x[2]);
                n_out_val[3] = r_s11_u[5];
                n_out_val[4] = r_s11_u[4];
                n_out_val[5] = r_s11_u[3];
            end else begin
                for (int i = 0; i < 6; i++) begin
                    n_out_val[i] = r_s11_u[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_val <= n_out_val;
            r_out_cnt <= n_out_cnt;
            r_out_st  <= n_out_st;
        end
    end

    assign o_out_valid   = r_out_v;
    assign o_value_0     = r_out_val[0];
    assign o_value_1     = r_out_val[1];
    assign o_value_2     = r_out_val[2];
    assign o_value_3     = r_out_val[3];
    assign o_value_4     = r_out_val[4];
    assign o_value_5     = r_out_val[5];
    assign o_value_6     = r_out_val[6];
    assign o_value_7     = r_out_val[7];
    assign o_value_8     = r_out_val[8];
    assign o_value_count = r_out_cnt;
    assign o_status      = r_out_st;

endmodule
